FILE: src/json_string_unescape_validate_macros.svh
// Assertion helpers for json_string_unescape_validate.sv.
// Each expects signals named clk and rst_n in the enclosing module.
`ifndef JSON_STRING_UNESCAPE_VALIDATE_MACROS_SVH
`define JSON_STRING_UNESCAPE_VALIDATE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define JSU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define JSU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/jsu_pkg.sv
package jsu_pkg;

    // Largest number of decoded bytes one input word can produce
    localparam int unsigned RES_BYTES = 4;
    // Width of the reported decoded length
    localparam int unsigned COUNT_OUT_BITS = 16;

    // Results produced by one input word: decoded bytes, then an optional final
    typedef struct packed {
        logic [RES_BYTES-1:0][7:0] bytes;
        logic [2:0]                nbytes;
        logic                      fin;
        logic                      status;
        logic [COUNT_OUT_BITS-1:0] count;
    } jsu_result_t;

endpackage

FILE: src/jsu_core.sv
module jsu_core
    import jsu_pkg::*;
#(
    parameter int unsigned COUNT_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [7:0]  text_byte,
    input  logic        last_byte,
    output jsu_result_t res
);

    typedef enum logic [3:0] {
        PH_OPEN       = 4'd0,
        PH_BODY       = 4'd1,
        PH_ESC        = 4'd2,
        PH_HEX1       = 4'd3,
        PH_PAIR_BS    = 4'd4,
        PH_PAIR_U     = 4'd5,
        PH_HEX2       = 4'd6,
        PH_UTF_SECOND = 4'd7,
        PH_UTF_MORE   = 4'd8,
        PH_DONE       = 4'd9
    } phase_t;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CTRL_LIMIT = 8'h20;
    localparam logic [7:0] CONT_LO   = 8'h80;
    localparam logic [7:0] CONT_HI   = 8'hBF;
    localparam logic [15:0] HI_SURR_LO = 16'hD800;
    localparam logic [15:0] HI_SURR_HI = 16'hDBFF;
    localparam logic [15:0] LO_SURR_LO = 16'hDC00;
    localparam logic [15:0] LO_SURR_HI = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE  = 21'h10000;

    // Decoded bytes of one code point
    typedef struct packed {
        logic [RES_BYTES-1:0][7:0] bytes;
        logic [2:0]                nbytes;
    } utf8_seq_t;

    // Hex digit value; bit 4 set for a non-hex byte
    function automatic logic [4:0] hex_of(input logic [7:0] b);
        logic [4:0] v;
        begin
            v = 5'h10;
            if (b >= 8'h30 && b <= 8'h39)
            begin
                v = 5'(b - 8'h30);
            end
            else if (b >= 8'h61 && b <= 8'h66)
            begin
                v = 5'(b - 8'h57);
            end
            else if (b >= 8'h41 && b <= 8'h46)
            begin
                v = 5'(b - 8'h37);
            end
            return v;
        end
    endfunction

    // UTF-8 encoder for one code point
    function automatic utf8_seq_t utf8_encode(input logic [20:0] cp);
        utf8_seq_t s;
        begin
            s = '0;
            if (cp <= 21'h7F)
            begin
                s.bytes[0] = cp[7:0];
                s.nbytes   = 3'd1;
            end
            else if (cp <= 21'h7FF)
            begin
                s.bytes[0] = {3'b110, cp[10:6]};
                s.bytes[1] = {2'b10, cp[5:0]};
                s.nbytes   = 3'd2;
            end
            else if (cp <= 21'hFFFF)
            begin
                s.bytes[0] = {4'b1110, cp[15:12]};
                s.bytes[1] = {2'b10, cp[11:6]};
                s.bytes[2] = {2'b10, cp[5:0]};
                s.nbytes   = 3'd3;
            end
            else
            begin
                s.bytes[0] = {5'b11110, cp[20:18]};
                s.bytes[1] = {2'b10, cp[17:12]};
                s.bytes[2] = {2'b10, cp[11:6]};
                s.bytes[3] = {2'b10, cp[5:0]};
                s.nbytes   = 3'd4;
            end
            return s;
        end
    endfunction

    phase_t                phase_reg, phase_next;
    logic [15:0]           hex_accum_reg, hex_accum_next;
    logic [1:0]            hex_digits_reg, hex_digits_next;
    logic [9:0]            high_half_reg, high_half_next;
    logic [1:0]            utf8_rem_reg, utf8_rem_next;
    logic [7:0]            low_bound_reg, low_bound_next;
    logic [7:0]            high_bound_reg, high_bound_next;
    logic                  failed_reg, failed_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;

    logic [4:0]            hex_val;
    logic [15:0]           acc_shift;
    logic                  hex_done;
    logic                  bad;
    logic                  fin;
    utf8_seq_t             emit;
    utf8_seq_t             cp_seq_bmp;
    utf8_seq_t             cp_seq_supp;
    logic [20:0]           supp_cp;
    logic [1:0]            rem_dec;
    logic [COUNT_BITS:0]   count_sum;
    logic [31:0]           count_wide;

    // Shared hex digit path for both escape halves
    assign hex_val   = hex_of(text_byte);
    assign acc_shift = {hex_accum_reg[11:0], hex_val[3:0]};
    assign hex_done  = (hex_digits_reg == 2'd3);
    assign supp_cp   = SUPP_BASE + 21'({high_half_reg, acc_shift[9:0]});
    assign cp_seq_bmp  = utf8_encode(21'(acc_shift));
    assign cp_seq_supp = utf8_encode(supp_cp);
    assign rem_dec   = (utf8_rem_reg != 2'd0) ? utf8_rem_reg - 2'd1 : 2'd0;

    // Per-word decode
    always_comb
    begin
        phase_next      = phase_reg;
        hex_accum_next  = hex_accum_reg;
        hex_digits_next = hex_digits_reg;
        high_half_next  = high_half_reg;
        utf8_rem_next   = utf8_rem_reg;
        low_bound_next  = low_bound_reg;
        high_bound_next = high_bound_reg;
        failed_next     = failed_reg;
        bad             = 1'b0;
        emit            = '0;

        if (!failed_reg)
        begin
            unique case (phase_reg)
                PH_OPEN:
                begin
                    if (text_byte == CH_QUOTE)
                    begin
                        phase_next = PH_BODY;
                    end
                    else
                    begin
                        bad = 1'b1;
                    end
                end
                PH_BODY:
                begin
                    priority if (text_byte == CH_QUOTE)
                    begin
                        phase_next = PH_DONE;
                    end
                    else if (text_byte < CTRL_LIMIT)
                    begin
                        bad = 1'b1;
                    end
                    else if (text_byte == CH_BSLASH)
                    begin
                        phase_next = PH_ESC;
                    end
                    else if (text_byte < CONT_LO)
                    begin
                        emit.bytes[0] = text_byte;
                        emit.nbytes   = 3'd1;
                    end
                    else
                    begin
                        // Multi-byte lead: set bounds for the second byte
                        low_bound_next  = CONT_LO;
                        high_bound_next = CONT_HI;
                        priority if (text_byte >= 8'hC2 && text_byte <= 8'hDF)
                        begin
                            utf8_rem_next = 2'd1;
                        end
                        else if (text_byte >= 8'hE0 && text_byte <= 8'hEF)
                        begin
                            utf8_rem_next = 2'd2;
                            if (text_byte == 8'hE0)
                            begin
                                low_bound_next = 8'hA0;
                            end
                            if (text_byte == 8'hED)
                            begin
                                high_bound_next = 8'h9F;
                            end
                        end
                        else if (text_byte >= 8'hF0 && text_byte <= 8'hF4)
                        begin
                            utf8_rem_next = 2'd3;
                            if (text_byte == 8'hF0)
                            begin
                                low_bound_next = 8'h90;
                            end
                            if (text_byte == 8'hF4)
                            begin
                                high_bound_next = 8'h8F;
                            end
                        end
                        else
                        begin
                            bad = 1'b1;
                        end
                        if (!bad)
                        begin
                            emit.bytes[0] = text_byte;
                            emit.nbytes   = 3'd1;
                            phase_next    = PH_UTF_SECOND;
                        end
                    end
                end
                PH_ESC:
                begin
                    phase_next = PH_BODY;
                    unique case (text_byte)
                        CH_QUOTE, CH_BSLASH, CH_SLASH:
                        begin
                            emit.bytes[0] = text_byte;
                            emit.nbytes   = 3'd1;
                        end
                        CH_B:
                        begin
                            emit.bytes[0] = 8'h08;
                            emit.nbytes   = 3'd1;
                        end
                        CH_F:
                        begin
                            emit.bytes[0] = 8'h0C;
                            emit.nbytes   = 3'd1;
                        end
                        CH_N:
                        begin
                            emit.bytes[0] = 8'h0A;
                            emit.nbytes   = 3'd1;
                        end
                        CH_R:
                        begin
                            emit.bytes[0] = 8'h0D;
                            emit.nbytes   = 3'd1;
                        end
                        CH_T:
                        begin
                            emit.bytes[0] = 8'h09;
                            emit.nbytes   = 3'd1;
                        end
                        CH_U:
                        begin
                            phase_next      = PH_HEX1;
                            hex_accum_next  = '0;
                            hex_digits_next = '0;
                        end
                        default:
                        begin
                            bad = 1'b1;
                        end
                    endcase
                end
                PH_HEX1, PH_HEX2:
                begin
                    if (hex_val[4])
                    begin
                        bad = 1'b1;
                    end
                    else
                    begin
                        hex_accum_next  = acc_shift;
                        hex_digits_next = hex_digits_reg + 2'd1;
                        if (hex_done && phase_reg == PH_HEX1)
                        begin
                            priority if (acc_shift >= HI_SURR_LO && acc_shift <= HI_SURR_HI)
                            begin
                                high_half_next = acc_shift[9:0];
                                phase_next     = PH_PAIR_BS;
                            end
                            else if (acc_shift >= LO_SURR_LO && acc_shift <= LO_SURR_HI)
                            begin
                                bad = 1'b1;
                            end
                            else
                            begin
                                emit       = cp_seq_bmp;
                                phase_next = PH_BODY;
                            end
                        end
                        else if (hex_done)
                        begin
                            if (acc_shift < LO_SURR_LO || acc_shift > LO_SURR_HI)
                            begin
                                bad = 1'b1;
                            end
                            else
                            begin
                                emit       = cp_seq_supp;
                                phase_next = PH_BODY;
                            end
                        end
                    end
                end
                PH_PAIR_BS:
                begin
                    if (text_byte == CH_BSLASH)
                    begin
                        phase_next = PH_PAIR_U;
                    end
                    else
                    begin
                        bad = 1'b1;
                    end
                end
                PH_PAIR_U:
                begin
                    if (text_byte == CH_U)
                    begin
                        phase_next      = PH_HEX2;
                        hex_accum_next  = '0;
                        hex_digits_next = '0;
                    end
                    else
                    begin
                        bad = 1'b1;
                    end
                end
                PH_UTF_SECOND, PH_UTF_MORE:
                begin
                    if ((phase_reg == PH_UTF_SECOND &&
                         (text_byte < low_bound_reg || text_byte > high_bound_reg)) ||
                        (phase_reg == PH_UTF_MORE &&
                         (text_byte < CONT_LO || text_byte > CONT_HI)))
                    begin
                        bad = 1'b1;
                    end
                    else
                    begin
                        emit.bytes[0] = text_byte;
                        emit.nbytes   = 3'd1;
                        utf8_rem_next = rem_dec;
                        phase_next    = (rem_dec == 2'd0) ? PH_BODY : PH_UTF_MORE;
                    end
                end
                default:
                begin
                    // After the closing quote, or an unused code
                    bad = 1'b1;
                end
            endcase

            // Token ended without its closing quote
            if (!bad && last_byte && phase_next != PH_DONE)
            begin
                bad = 1'b1;
            end
        end

        fin = !failed_reg && (bad || last_byte);

        // Saturating length update
        count_sum  = {1'b0, count_reg} + (COUNT_BITS+1)'(emit.nbytes);
        count_next = count_sum[COUNT_BITS] ? '1 : count_sum[COUNT_BITS-1:0];
        count_wide = 32'(count_next);

        res.bytes  = emit.bytes;
        res.nbytes = emit.nbytes;
        res.fin    = fin;
        res.status = bad;
        res.count  = fin ? count_wide[COUNT_OUT_BITS-1:0] : '0;

        // End of token or a malformed byte resets the decode state and length; failed then marks the rest of the token
        if (fin || (failed_reg && last_byte))
        begin
            phase_next      = PH_OPEN;
            hex_accum_next  = '0;
            hex_digits_next = '0;
            high_half_next  = '0;
            utf8_rem_next   = '0;
            low_bound_next  = CONT_LO;
            high_bound_next = CONT_HI;
            count_next      = '0;
            failed_next     = fin && bad && !last_byte;
        end
    end

    // Token state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_OPEN;
            hex_accum_reg  <= '0;
            hex_digits_reg <= '0;
            high_half_reg  <= '0;
            utf8_rem_reg   <= '0;
            low_bound_reg  <= CONT_LO;
            high_bound_reg <= CONT_HI;
            failed_reg     <= 1'b0;
            count_reg      <= '0;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            hex_accum_reg  <= hex_accum_next;
            hex_digits_reg <= hex_digits_next;
            high_half_reg  <= high_half_next;
            utf8_rem_reg   <= utf8_rem_next;
            low_bound_reg  <= low_bound_next;
            high_bound_reg <= high_bound_next;
            failed_reg     <= failed_next;
            count_reg      <= count_next;
        end
    end

endmodule

FILE: src/json_string_unescape_validate.sv
// Decodes one quoted JSON string token per run of input words (one raw byte each, tlast
// on the final byte) into UTF-8 output words, then one final word (tlast) with the
// status and the saturating decoded length. Each input byte is held in the input
// register; its results are then registered in the result stage. A byte that yields
// at most one result is accepted every cycle while m_tready is high. A byte that yields
// several results (up to four bytes of a \u code point plus the final word) holds the
// result stage until all have left, since the output port moves one word per cycle
// with m_tready high; the next byte with results waits behind it. After a malformed byte
// the final word is sent at once and the rest of the token, up to its tlast, is dropped.
`include "json_string_unescape_validate_macros.svh"

module json_string_unescape_validate
    import jsu_pkg::*;
#(
    parameter int unsigned COUNT_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // text_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // out_byte[7:0], status[8], decoded_count[24:9], zero
    output logic        m_tlast,   // is_final
    output logic        m_tuser    // byte_valid
);

    logic                      in_valid_reg, in_valid_next;
    logic [7:0]                in_byte_reg;
    logic                      in_last_reg;
    jsu_result_t               dec;
    logic                      advance;
    logic                      bundle_free;
    logic                      last_one;
    logic                      bundle_load;
    logic                      pop;
    logic [RES_BYTES-1:0][7:0] bytes_reg, bytes_next;
    logic [2:0]                nbytes_reg, nbytes_next;
    logic                      fin_reg, fin_next;
    logic                      status_reg;
    logic [COUNT_OUT_BITS-1:0] count_reg;
    logic                      s_accept;

    // Token decoder
    jsu_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .text_byte (in_byte_reg),
        .last_byte (in_last_reg),
        .res       (dec)
    );

    // Result stage handshake
    assign last_one    = (nbytes_reg == 3'd1 && !fin_reg) || (nbytes_reg == 3'd0 && fin_reg);
    assign bundle_free = !m_tvalid || (m_tready && last_one);
    assign advance     = in_valid_reg && (bundle_free || (dec.nbytes == 3'd0 && !dec.fin));
    assign bundle_load = advance && (dec.nbytes != 3'd0 || dec.fin);
    assign pop         = m_tvalid && m_tready;
    assign s_tready    = !in_valid_reg || advance;
    assign s_accept    = s_tvalid && s_tready;
    assign in_valid_next = s_accept || (in_valid_reg && !advance);

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // Next contents of the result stage: load, shift out one byte, or drop the final
    always_comb
    begin
        bytes_next  = bytes_reg;
        nbytes_next = nbytes_reg;
        fin_next    = fin_reg;
        if (bundle_load)
        begin
            bytes_next  = dec.bytes;
            nbytes_next = dec.nbytes;
            fin_next    = dec.fin;
        end
        else if (pop)
        begin
            if (nbytes_reg != 3'd0)
            begin
                bytes_next  = {8'h00, bytes_reg[RES_BYTES-1:1]};
                nbytes_next = nbytes_reg - 3'd1;
            end
            else
            begin
                fin_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nbytes_reg <= '0;
            fin_reg    <= 1'b0;
        end
        else
        begin
            nbytes_reg <= nbytes_next;
            fin_reg    <= fin_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bytes_reg <= bytes_next;
        if (bundle_load)
        begin
            status_reg <= dec.status;
            count_reg  <= dec.count;
        end
    end

    // Output word
    assign m_tvalid = (nbytes_reg != 3'd0) || fin_reg;
    assign m_tuser  = (nbytes_reg != 3'd0);
    assign m_tlast  = (nbytes_reg == 3'd0) && fin_reg;
    assign m_tdata  = {7'd0,
                       m_tlast ? count_reg : {COUNT_OUT_BITS{1'b0}},
                       m_tlast & status_reg,
                       m_tuser ? bytes_reg[0] : 8'h00};

    `JSU_ASSERT_NOW(a_load_only_when_free, bundle_load, bundle_free,
        "result stage overwritten while words remain")
    `JSU_ASSERT_NOW(a_byte_word_clean, m_tvalid && m_tuser, !m_tlast && m_tdata[24:8] == 17'd0,
        "byte word carries final fields")
    `JSU_ASSERT_NEXT(a_stall_keeps_input, in_valid_reg && !advance,
        in_valid_reg && $stable(in_byte_reg) && $stable(in_last_reg),
        "input register lost a pending word")

endmodule
